[src/drsi_pkg.sv]
`default_nettype none
package drsi_pkg;

  localparam int OP_W    = 2;
  localparam int VALUE_W = 32;
  localparam int RANK_W  = 11;

  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD_RD,
    ST_LOAD_CMP,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_SHIFT,
    ST_INSERT,
    ST_DONE
  } drsi_state_t;

  typedef struct packed {
    logic accept;
    logic load_rd;
    logic load_eval;
    logic srch_rd;
    logic srch_eval;
    logic srch_end;
    logic shift_step;
    logic insert;
    logic publish;
  } drsi_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic srch_done;
    logic need_insert;
    logic shift_done;
    logic out_busy;
  } drsi_stat_t;

endpackage
`default_nettype wire

[src/drsi_ctrl.sv]
`default_nettype none
module drsi_ctrl (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  input  wire logic [drsi_pkg::OP_W-1:0] in_op,
  output logic                         in_ready,
  input  wire drsi_pkg::drsi_stat_t    stat,
  output drsi_pkg::drsi_cmd_t          cmd
);
  import drsi_pkg::*;

  drsi_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_op == OP_LOAD && !stat.cnt_zero) begin
            state_nxt = ST_LOAD_RD;
          end else if (in_op == OP_QUERY) begin
            state_nxt = ST_SRCH_RD;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_LOAD_RD:  state_nxt = ST_LOAD_CMP;
      ST_LOAD_CMP: state_nxt = ST_DONE;
      ST_SRCH_RD: begin
        if (stat.srch_done) begin
          state_nxt = stat.need_insert ? ST_SHIFT : ST_DONE;
        end else begin
          state_nxt = ST_SRCH_CMP;
        end
      end
      ST_SRCH_CMP: state_nxt = ST_SRCH_RD;
      ST_SHIFT: begin
        if (stat.shift_done) begin
          state_nxt = ST_INSERT;
        end
      end
      ST_INSERT: state_nxt = ST_DONE;
      ST_DONE: begin
        if (!stat.out_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_LOAD_RD:  cmd.load_rd   = 1'b1;
      ST_LOAD_CMP: cmd.load_eval = 1'b1;
      ST_SRCH_RD: begin
        cmd.srch_rd  = !stat.srch_done;
        cmd.srch_end = stat.srch_done;
      end
      ST_SRCH_CMP: cmd.srch_eval  = 1'b1;
      ST_SHIFT:    cmd.shift_step = 1'b1;
      ST_INSERT:   cmd.insert     = 1'b1;
      ST_DONE:     cmd.publish    = !stat.out_busy;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

[src/drsi_dp.sv]
`default_nettype none
module drsi_dp #(
  parameter int TABLE_DEPTH = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [drsi_pkg::OP_W-1:0]     in_op,
  input  wire logic [drsi_pkg::VALUE_W-1:0]  in_value,
  input  wire drsi_pkg::drsi_cmd_t           cmd,
  output drsi_pkg::drsi_stat_t               stat,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [drsi_pkg::RANK_W-1:0]        out_rank,
  output logic                               out_table_full,
  output logic                               out_order_error
);
  import drsi_pkg::*;

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int RW = CW + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  logic [VALUE_W-1:0] mem [TABLE_DEPTH];
  logic [VALUE_W-1:0] rd_data_r;
  logic [VALUE_W-1:0] val_r;
  logic [CW-1:0]      cnt_r, lo_r, hi_r, idx_r, rem_r, paddr_r, mid;
  logic               found_r, pend_r;
  logic [RW-1:0]      res_rank_r;
  logic               res_full_r, res_err_r;
  logic               out_valid_r, out_full_r, out_err_r;
  logic [RANK_W-1:0]  out_rank_r;
  logic [RW+RANK_W-1:0] rank_ext;

  logic               we, re;
  logic [AW-1:0]      wa, ra;
  logic [VALUE_W-1:0] wd;

  assign mid = lo_r + ((hi_r - lo_r) >> 1);

  // memory port steering, states are exclusive
  always_comb begin
    we = 1'b0;
    wa = '0;
    wd = val_r;
    re = 1'b0;
    ra = '0;
    if (cmd.accept && in_op == OP_LOAD && cnt_r == '0) begin
      we = 1'b1;
      wd = in_value;
    end
    if (cmd.load_eval && val_r < rd_data_r && cnt_r != DEPTH_C) begin
      we = 1'b1;
      wa = cnt_r[AW-1:0];
    end
    if (cmd.load_rd) begin
      re = 1'b1;
      ra = AW'(cnt_r - ONE_C);
    end
    if (cmd.srch_rd) begin
      re = 1'b1;
      ra = mid[AW-1:0];
    end
    if (cmd.shift_step) begin
      re = rem_r != '0;
      ra = idx_r[AW-1:0];
      if (pend_r) begin
        we = 1'b1;
        wa = AW'(paddr_r + ONE_C);
        wd = rd_data_r;
      end
    end
    if (cmd.insert) begin
      we = 1'b1;
      wa = lo_r[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_data_r <= mem[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      if (cmd.accept) begin
        val_r      <= in_value;
        lo_r       <= '0;
        hi_r       <= cnt_r;
        found_r    <= 1'b0;
        res_rank_r <= '0;
        res_full_r <= 1'b0;
        res_err_r  <= 1'b0;
        if (in_op == OP_CLEAR) begin
          cnt_r <= '0;
        end else if (in_op == OP_LOAD && cnt_r == '0) begin
          cnt_r      <= ONE_C;
          res_rank_r <= RW'(1);
        end
      end
      if (cmd.load_eval) begin
        if (val_r == rd_data_r) begin
          res_rank_r <= RW'(cnt_r);
        end else if (val_r > rd_data_r) begin
          res_err_r <= 1'b1;
        end else begin
          res_rank_r <= RW'(cnt_r) + RW'(1);
          if (cnt_r != DEPTH_C) begin
            cnt_r <= cnt_r + ONE_C;
          end else begin
            res_full_r <= 1'b1;
          end
        end
      end
      if (cmd.srch_eval) begin
        if (rd_data_r > val_r) begin
          lo_r <= mid + ONE_C;
        end else begin
          hi_r <= mid;
        end
        if (rd_data_r == val_r) begin
          found_r <= 1'b1;
        end
      end
      if (cmd.srch_end) begin
        res_rank_r <= RW'(lo_r) + RW'(1);
        res_full_r <= !found_r && cnt_r == DEPTH_C;
        idx_r      <= cnt_r - ONE_C;
        rem_r      <= cnt_r - lo_r;
        pend_r     <= 1'b0;
      end
      if (cmd.shift_step) begin
        pend_r <= rem_r != '0;
        if (rem_r != '0) begin
          paddr_r <= idx_r;
          idx_r   <= idx_r - ONE_C;
          rem_r   <= rem_r - ONE_C;
        end
      end
      if (cmd.insert) begin
        cnt_r <= cnt_r + ONE_C;
      end
      if (cmd.publish) begin
        out_valid_r <= 1'b1;
        out_rank_r  <= rank_ext[RANK_W-1:0];
        out_full_r  <= res_full_r;
        out_err_r   <= res_err_r;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign rank_ext = {{RANK_W{1'b0}}, res_rank_r};

  assign stat.cnt_zero    = cnt_r == '0;
  assign stat.srch_done   = lo_r >= hi_r;
  assign stat.need_insert = !found_r && cnt_r != DEPTH_C;
  assign stat.shift_done  = rem_r == '0 && !pend_r;
  assign stat.out_busy    = out_valid_r && !out_ready;

  assign out_valid       = out_valid_r;
  assign out_rank        = out_rank_r;
  assign out_table_full  = out_full_r;
  assign out_order_error = out_err_r;

endmodule
`default_nettype wire

[src/dense_rank_sorted_insert.sv]
// dense rank sorted insert
// keeps distinct 32-bit values in a descending table held in one memory
// input channel: in_valid/in_ready with in_op (clear, load, query) and in_value
// result channel: out_valid/out_ready with out_rank, out_table_full,
//   out_order_error; exactly one result item per input item
// one item is worked on at a time; in_ready is high only when idle
// clear and first load go straight to the result; other loads read the last
//   entry and compare it with the value
// query: a binary search alternating memory reads and compares; when the value
//   is absent and the table not full, a shift and a write then open the slot
//   (one entry moved per cycle through the single memory port pair)
// results sit in an output register; a new item is taken while it waits,
//   and a stalled receiver only holds the next result in its last state
// reset empties the table (count to zero) and drops any pending result;
//   memory contents need no clearing since only entries below count are read
`default_nettype none
module dense_rank_sorted_insert #(
  parameter int TABLE_DEPTH = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [drsi_pkg::OP_W-1:0]     in_op,
  input  wire logic [drsi_pkg::VALUE_W-1:0]  in_value,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [drsi_pkg::RANK_W-1:0]        out_rank,
  output logic                               out_table_full,
  output logic                               out_order_error
);
  import drsi_pkg::*;

  drsi_cmd_t  cmd;
  drsi_stat_t stat;

  // sequencer: search loop, shift loop, result hand-off
  drsi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_op),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // table memory, search bounds, count and result register
  drsi_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_op           (in_op),
    .in_value        (in_value),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_rank        (out_rank),
    .out_table_full  (out_table_full),
    .out_order_error (out_order_error)
  );

endmodule
`default_nettype wire

[src/drsi_checker.sv]
`default_nettype none
module drsi_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [10:0] out_rank,
  input wire logic        out_table_full,
  input wire logic        out_order_error
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_rank))
    else $error("result dropped or changed while stalled");

  a_err_rank: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_order_error |-> out_rank == 11'd0 && !out_table_full)
    else $error("order error with nonzero rank or full flag");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in work");

  a_full_rank: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_table_full |-> out_rank != 11'd0)
    else $error("full flag with zero rank");

endmodule

bind dense_rank_sorted_insert drsi_checker u_drsi_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_rank        (out_rank),
  .out_table_full  (out_table_full),
  .out_order_error (out_order_error)
);
`default_nettype wire

[bench/tb.sv]
`default_nettype none
module tb;
  import drsi_pkg::*;

  localparam int DEPTH     = 1024;
  localparam int MAX_CYC   = 3000000;
  localparam int N_RANDOM  = 560;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic              full;
    logic              order_err;
  } rank_res_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [OP_W-1:0] in_op;
  logic [VALUE_W-1:0] in_value;
  logic out_valid;
  logic out_ready;
  logic [RANK_W-1:0] out_rank;
  logic out_table_full;
  logic out_order_error;

  dense_rank_sorted_insert #(.TABLE_DEPTH(DEPTH)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_op(in_op), .in_value(in_value),
    .out_valid(out_valid), .out_ready(out_ready), .out_rank(out_rank),
    .out_table_full(out_table_full), .out_order_error(out_order_error)
  );

  // clock, period 4
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state: descending distinct values
  logic [VALUE_W-1:0] score_tbl [DEPTH];
  int unsigned        score_cnt;

  req_t      pending_items[$];
  rank_res_t expected_ranks[$];
  int        mismatches;
  int        cycle_cnt;
  bit        stim_done;
  bit        hold_rx;        // long receiver hold-off request
  int        rx_hold_left;
  bit        drain_req;      // sender pauses until all results are in
  int        drain_marks[$]; // item indexes before which the sender drains
  int        sent_cnt;

  // dense rank insert, computed on the predictor's own table
  function automatic rank_res_t predict_rank(req_t it);
    rank_res_t r;
    int unsigned lo, hi, mid;
    r = '0;
    case (it.op)
      OP_CLEAR: begin
        score_cnt = 0;
      end
      OP_LOAD: begin
        if (score_cnt == 0) begin
          score_tbl[0] = it.value;
          score_cnt = 1;
          r.rank = RANK_W'(1);
        end else if (it.value == score_tbl[score_cnt-1]) begin
          r.rank = score_cnt[RANK_W-1:0];
        end else if (it.value > score_tbl[score_cnt-1]) begin
          r.order_err = 1'b1;
        end else if (score_cnt < DEPTH) begin
          score_tbl[score_cnt] = it.value;
          score_cnt++;
          r.rank = score_cnt[RANK_W-1:0];
        end else begin
          r.rank = RANK_W'(score_cnt + 1);
          r.full = 1'b1;
        end
      end
      OP_QUERY: begin
        lo = 0;
        hi = score_cnt;
        while (lo < hi) begin
          mid = lo + (hi - lo) / 2;
          if (score_tbl[mid] > it.value) lo = mid + 1;
          else hi = mid;
        end
        r.rank = RANK_W'(lo + 1);
        if (lo < score_cnt && score_tbl[lo] == it.value) begin
          // already present, table unchanged
        end else if (score_cnt < DEPTH) begin
          for (int i = score_cnt; i > lo; i--) score_tbl[i] = score_tbl[i-1];
          score_tbl[lo] = it.value;
          score_cnt++;
        end else begin
          r.full = 1'b1;
        end
      end
      default: ;  // unused op code: all zero, no state change
    endcase
    return r;
  endfunction

  function automatic req_t mk(logic [OP_W-1:0] op, logic [VALUE_W-1:0] v);
    req_t it;
    it.op = op;
    it.value = v;
    return it;
  endfunction

  // stimulus
  initial begin
    int unsigned v;
    int n;
    int kind;
    // directed: extremes, every op, every special case apart from a full table
    pending_items.push_back(mk(OP_QUERY, 32'h0));          // query into empty table
    pending_items.push_back(mk(OP_CLEAR, 32'hFFFF_FFFF));
    pending_items.push_back(mk(OP_LOAD, 32'hFFFF_FFFF));   // load into empty
    pending_items.push_back(mk(OP_LOAD, 32'hFFFF_FFFF));   // repeat merged
    pending_items.push_back(mk(OP_LOAD, 32'h8000_0000));   // append below
    pending_items.push_back(mk(OP_LOAD, 32'h9000_0000));   // above last: order error
    pending_items.push_back(mk(OP_LOAD, 32'h0000_0001));
    pending_items.push_back(mk(OP_QUERY, 32'h8000_0000));  // present
    pending_items.push_back(mk(OP_QUERY, 32'hC000_0000));  // insert in middle
    pending_items.push_back(mk(OP_QUERY, 32'h0));          // insert at tail
    pending_items.push_back(mk(OP_QUERY, 32'hFFFF_FFFF));  // present at head
    pending_items.push_back(mk(2'd3, 32'h5555_AAAA));      // unused op
    pending_items.push_back(mk(OP_LOAD, 32'h0));           // repeat of zero
    pending_items.push_back(mk(OP_CLEAR, 32'h0));
    pending_items.push_back(mk(OP_LOAD, 32'h0));
    pending_items.push_back(mk(OP_LOAD, 32'h1));           // order error
    pending_items.push_back(mk(OP_QUERY, 32'hAAAA_5555));
    pending_items.push_back(mk(OP_CLEAR, 32'h0));
    drain_marks.push_back(pending_items.size());
    // random: mostly queries over small value pools, load runs, rare clears
    n = 0;
    while (n < N_RANDOM) begin
      kind = $urandom_range(0, 99);
      if (kind < 4) begin
        pending_items.push_back(mk(OP_CLEAR, $urandom));
        n++;
      end else if (kind < 6) begin
        pending_items.push_back(mk(2'd3, $urandom));
        n++;
      end else if (kind < 20) begin
        // a descending load run with repeats and an occasional out-of-order value
        v = $urandom;
        for (int k = 0; k < $urandom_range(2, 8); k++) begin
          case ($urandom_range(0, 5))
            0: ;
            1: v = v + $urandom_range(1, 100);
            default: v = v - ($urandom % (v / 2 + 1));
          endcase
          pending_items.push_back(mk(OP_LOAD, v));
          n++;
        end
      end else begin
        case ($urandom_range(0, 3))
          0: v = $urandom;
          1: v = $urandom_range(0, 40);
          2: v = 32'hFFFF_FFFF - $urandom_range(0, 40);
          default: v = 32'(1) << $urandom_range(0, 31);
        endcase
        pending_items.push_back(mk(OP_QUERY, v));
        n++;
      end
      if (n == N_RANDOM / 2) drain_marks.push_back(pending_items.size());
    end
    wait (stim_done);
  end

  // driver
  int tx_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_op    <= '0;
      in_value <= '0;
      tx_gap   <= 0;
      drain_req <= 1'b0;
      sent_cnt <= 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_ranks.push_back(predict_rank(mk(in_op, in_value)));
        sent_cnt <= sent_cnt + 1;
      end
      if (!(in_valid && !in_ready)) begin
        // current item gone or none offered: pick the next one
        if (drain_marks.size() > 0 && drain_marks[0] == sent_cnt + (in_valid ? 1 : 0)
            && !drain_req) begin
          drain_req <= 1'b1;
          in_valid <= 1'b0;
        end else if (drain_req) begin
          in_valid <= 1'b0;
          if (expected_ranks.size() == 0 && !out_valid) begin
            drain_req <= 1'b0;
            void'(drain_marks.pop_front());
          end
        end else if (tx_gap > 0) begin
          in_valid <= 1'b0;
          tx_gap <= tx_gap - 1;
        end else if (pending_items.size() > 0) begin
          req_t it;
          it = pending_items.pop_front();
          in_valid <= 1'b1;
          in_op    <= it.op;
          in_value <= it.value;
          // stretches with no gaps between items
          tx_gap <= ((sent_cnt > 200 && sent_cnt < 400) || $urandom_range(0, 3) == 0)
                    ? 0 : $urandom_range(0, 7);
        end else begin
          in_valid <= 1'b0;
          stim_done <= 1'b1;
        end
      end
    end
  end

  // receiver ready: random stalls plus one long hold-off
  int rx_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_gap <= 0;
      rx_hold_left <= 0;
      hold_rx <= 1'b0;
    end else if (!hold_rx && sent_cnt == 420) begin
      hold_rx <= 1'b1;
      rx_hold_left <= 300;
      out_ready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      rx_hold_left <= rx_hold_left - 1;
      out_ready <= 1'b0;
    end else if (out_valid && out_ready) begin
      rx_gap <= (sent_cnt > 450 && sent_cnt < 520) ? 0 : $urandom_range(0, 7);
      out_ready <= ($urandom_range(0, 1) != 0);
    end else if (rx_gap > 0) begin
      rx_gap <= rx_gap - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_ranks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result item: rank=%0d full=%0b order=%0b",
                   out_rank, out_table_full, out_order_error);
      end else begin
        rank_res_t e;
        e = expected_ranks.pop_front();
        if (out_rank !== e.rank || out_table_full !== e.full
            || out_order_error !== e.order_err) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp rank=%0d full=%0b order=%0b got rank=%0d full=%0b order=%0b",
                     e.rank, e.full, e.order_err, out_rank, out_table_full,
                     out_order_error);
        end
      end
    end
  end

  // reset, end of run and timeout
  initial begin
    in_valid = 1'b0;
    in_op = '0;
    in_value = '0;
    out_ready = 1'b0;
    stim_done = 1'b0;
    mismatches = 0;
    score_cnt = 0;
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    wait (stim_done && expected_ranks.size() == 0);
    repeat (DEPTH + 50) @(posedge clk);
    if (mismatches == 0 && expected_ranks.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= MAX_CYC) begin
      $display("Simulation FAILED");
      $finish;
    end
  end
  initial cycle_cnt = 0;

endmodule
`default_nettype wire

[sim.f]
src/drsi_pkg.sv
src/drsi_ctrl.sv
src/drsi_dp.sv
src/dense_rank_sorted_insert.sv
src/drsi_checker.sv
bench/tb.sv
